// File: rtl/mcit_pkg.sv
package mcit_pkg;

    // default field widths
    localparam int MCIT_COORD_BITS = 16;
    localparam int MCIT_FRAC_BITS  = 8;

    // contact distance after reset (0.5 in Q8.8)
    localparam int MCIT_CONTACT_RESET = 128;

    // result codes
    typedef enum logic [1:0] {
        OUT_OVERLAP = 2'd0,
        OUT_CONTACT = 2'd1,
        OUT_NONE    = 2'd2
    } outcome_t;

endpackage

// File: rtl/mcit_if.sv
// input word: two circles, positions and velocities
interface mcit_in_if
    import mcit_pkg::*;
#(
    parameter int W = MCIT_COORD_BITS
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] first_x;
    logic signed [W-1:0] first_y;
    logic signed [W-1:0] first_vx;
    logic signed [W-1:0] first_vy;
    logic signed [W-1:0] second_x;
    logic signed [W-1:0] second_y;
    logic signed [W-1:0] second_vx;
    logic signed [W-1:0] second_vy;

    modport source (output valid, first_x, first_y, first_vx, first_vy,
                    second_x, second_y, second_vx, second_vy, input ready);
    modport sink   (input valid, first_x, first_y, first_vx, first_vy,
                    second_x, second_y, second_vx, second_vy, output ready);
endinterface

// result word
interface mcit_out_if
    import mcit_pkg::*;
#(
    parameter int W = MCIT_COORD_BITS
);
    logic         valid;
    logic         ready;
    logic [1:0]   outcome;
    logic [W-1:0] impact_time;
    logic         time_saturated;

    modport source (output valid, outcome, impact_time, time_saturated, input ready);
    modport sink   (input valid, outcome, impact_time, time_saturated, output ready);
endinterface

// contact distance write channel
interface mcit_cfg_if
    import mcit_pkg::*;
#(
    parameter int W = MCIT_COORD_BITS
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/mcit_sqrt_cell.sv
// one digit of the integer square root: tries root bit BIT
module mcit_sqrt_cell
    import mcit_pkg::*;
#(
    parameter int NW  = 70,
    parameter int RW  = 34,
    parameter int BIT = 0,
    parameter int SW  = 70
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] in_rem,
    input  logic [RW-1:0] in_root,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [NW-1:0] out_rem,
    output logic [RW-1:0] out_root,
    output logic [SW-1:0] out_side
);

    logic          valid_reg;
    logic [NW-1:0] rem_reg, rem_next;
    logic [RW-1:0] root_reg, root_next;
    logic [SW-1:0] side_reg;
    logic [NW-1:0] trial;
    logic          take;

    // (root + 2^BIT)^2 - root^2; root bits lie above BIT so OR is an add
    always_comb
    begin
        trial     = (NW'(in_root) << (BIT + 1)) | (NW'(1) << (2 * BIT));
        take      = (in_rem >= trial);
        rem_next  = take ? (in_rem - trial) : in_rem;
        root_next = take ? (in_root | (RW'(1) << BIT)) : in_root;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

// File: rtl/mcit_div_cell.sv
// one restoring division step: quotient bit BIT
module mcit_div_cell
    import mcit_pkg::*;
#(
    parameter int RW  = 60,
    parameter int DW  = 35,
    parameter int QW  = 17,
    parameter int BIT = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [RW-1:0] in_rem,
    input  logic [DW-1:0] in_den,
    input  logic [QW-1:0] in_quo,
    input  logic [1:0]    in_code,
    output logic          out_valid,
    output logic [RW-1:0] out_rem,
    output logic [DW-1:0] out_den,
    output logic [QW-1:0] out_quo,
    output logic [1:0]    out_code
);

    logic          valid_reg;
    logic [RW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] quo_reg, quo_next;
    logic [1:0]    code_reg;
    logic [RW-1:0] trial;
    logic          take;

    always_comb
    begin
        trial    = RW'(in_den) << BIT;
        take     = (in_rem >= trial);
        rem_next = take ? (in_rem - trial) : in_rem;
        quo_next = take ? (in_quo | (QW'(1) << BIT)) : in_quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            den_reg  <= in_den;
            quo_reg  <= quo_next;
            code_reg <= in_code;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_quo   = quo_reg;
    assign out_code  = code_reg;

endmodule

// File: rtl/moving_circle_impact_time.sv
// Swept circle time of impact.
// src carries one word per pair of circles (positions and velocities, signed
// Q.FRAC_BITS); dst returns outcome, impact_time and time_saturated for it.
// cfg writes the contact distance (sum of radii); it is always ready and
// should be written only while no word is in flight.
// From accept to dst.valid the word passes seven arithmetic stages, one square
// root cell per root bit (2*COORD_BITS + 2) and one divider cell per quotient
// bit (COORD_BITS + 1), then the output register.
// Throughput: one word per cycle while the chain is not held; every stage is a register of the chain.
// Reset empties the pipeline and sets the contact distance to 0.5.
// When dst stalls, a finished word waits in the output register and the
// chain keeps moving until its last cell holds a word; then the whole chain
// and src.ready hold until dst takes the waiting word.
module moving_circle_impact_time
    import mcit_pkg::*;
#(
    parameter int COORD_BITS = MCIT_COORD_BITS,
    parameter int FRAC_BITS  = MCIT_FRAC_BITS
)
(
    input  logic clk,
    input  logic rst_n,
    mcit_in_if.sink    src,
    mcit_out_if.source dst,
    mcit_cfg_if.sink   cfg
);

    localparam int W   = COORD_BITS;
    localparam int EW  = W + 1;              // difference width
    localparam int PW  = 2 * EW;             // a, c, m, root width
    localparam int HW  = PW / 2;             // partial product split
    localparam int SW  = PW + 1;             // signed sums
    localparam int NW  = 2 * PW + 2;         // root remainder
    localparam int XW  = 2 + 2 * PW;         // code, c, m beside the root
    localparam int DW  = PW + 1;             // divisor
    localparam int RW  = PW + W + FRAC_BITS + 2;
    localparam int QW  = W + 1;

    logic en;
    logic last_valid;

    // contact distance register
    logic [W-1:0] cd_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cd_reg <= W'(MCIT_CONTACT_RESET);
        end
        else if (cfg.valid)
        begin
            cd_reg <= cfg.data;
        end
    end

    // whole chain holds only when a finished word has nowhere to go
    assign en        = !(dst.valid && !dst.ready && last_valid);
    assign src.ready = en;

    // stage 1: relative position and velocity
    logic                 v1_reg;
    logic signed [EW-1:0] dx_reg, dy_reg, dvx_reg, dvy_reg;

    // stage 2: products
    logic                   v2_reg;
    logic signed [2*EW-1:0] pxx_reg, pyy_reg, pvx_reg, pvy_reg, hx_reg, hy_reg;
    logic [2*W-1:0]         d2_reg;

    // stage 3: coefficients and early flags
    logic                 v3_reg;
    logic signed [SW-1:0] p_s, c_s, a_s, h_s, mneg_s;
    logic                 over3_reg, az3_reg, away3_reg;
    logic [PW-1:0]        c3_reg, a3_reg, m3_reg;

    // stage 4: partial products of m*m and a*c
    logic             v4_reg;
    logic [PW+HW-1:0] mml_reg, mmh_reg, acl_reg, ach_reg;
    logic             over4_reg, az4_reg, away4_reg;
    logic [PW-1:0]    c4_reg, m4_reg;

    // stage 5: full products
    logic            v5_reg;
    logic [2*PW-1:0] m2_reg, ac_reg;
    logic            over5_reg, az5_reg, away5_reg;
    logic [PW-1:0]   c5_reg, m5_reg;

    // stage 6: discriminant and outcome code
    logic            v6_reg;
    logic [NW-1:0]   disc_reg;
    logic [1:0]      code6_reg;
    logic [PW-1:0]   c6_reg, m6_reg;
    logic [1:0]      code6_next;

    always_comb
    begin
        p_s    = SW'(pxx_reg) + SW'(pyy_reg);
        c_s    = p_s - SW'($signed({1'b0, d2_reg}));
        a_s    = SW'(pvx_reg) + SW'(pvy_reg);
        h_s    = SW'(hx_reg) + SW'(hy_reg);
        mneg_s = -h_s;
        priority if (over5_reg)
            code6_next = OUT_OVERLAP;
        else if (az5_reg || away5_reg || (m2_reg < ac_reg))
            code6_next = OUT_NONE;
        else
            code6_next = OUT_CONTACT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= src.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg  <= EW'(src.first_x) - EW'(src.second_x);
            dy_reg  <= EW'(src.first_y) - EW'(src.second_y);
            dvx_reg <= EW'(src.first_vx) - EW'(src.second_vx);
            dvy_reg <= EW'(src.first_vy) - EW'(src.second_vy);

            pxx_reg <= dx_reg * dx_reg;
            pyy_reg <= dy_reg * dy_reg;
            pvx_reg <= dvx_reg * dvx_reg;
            pvy_reg <= dvy_reg * dvy_reg;
            hx_reg  <= dx_reg * dvx_reg;
            hy_reg  <= dy_reg * dvy_reg;
            d2_reg  <= (2 * W)'(cd_reg) * (2 * W)'(cd_reg);

            over3_reg <= (c_s <= 0);
            az3_reg   <= (a_s == 0);
            away3_reg <= (h_s >= 0);
            c3_reg    <= c_s[PW-1:0];
            a3_reg    <= a_s[PW-1:0];
            m3_reg    <= mneg_s[PW-1:0];

            mml_reg   <= (PW + HW)'(m3_reg) * (PW + HW)'(m3_reg[HW-1:0]);
            mmh_reg   <= (PW + HW)'(m3_reg) * (PW + HW)'(m3_reg[PW-1:HW]);
            acl_reg   <= (PW + HW)'(a3_reg) * (PW + HW)'(c3_reg[HW-1:0]);
            ach_reg   <= (PW + HW)'(a3_reg) * (PW + HW)'(c3_reg[PW-1:HW]);
            over4_reg <= over3_reg;
            az4_reg   <= az3_reg;
            away4_reg <= away3_reg;
            c4_reg    <= c3_reg;
            m4_reg    <= m3_reg;

            m2_reg    <= (2 * PW)'(mml_reg) + ((2 * PW)'(mmh_reg) << HW);
            ac_reg    <= (2 * PW)'(acl_reg) + ((2 * PW)'(ach_reg) << HW);
            over5_reg <= over4_reg;
            az5_reg   <= az4_reg;
            away5_reg <= away4_reg;
            c5_reg    <= c4_reg;
            m5_reg    <= m4_reg;

            disc_reg  <= NW'(m2_reg - ac_reg);
            code6_reg <= code6_next;
            c6_reg    <= c5_reg;
            m6_reg    <= m5_reg;
        end
    end

    // square root chain, most significant root bit first
    logic          sq_v    [0:PW];
    logic [NW-1:0] sq_rem  [0:PW];
    logic [PW-1:0] sq_root [0:PW];
    logic [XW-1:0] sq_side [0:PW];

    assign sq_v[0]    = v6_reg;
    assign sq_rem[0]  = disc_reg;
    assign sq_root[0] = '0;
    assign sq_side[0] = {code6_reg, c6_reg, m6_reg};

    for (genvar i = 0; i < PW; i++)
    begin : g_sqrt
        mcit_sqrt_cell #(
            .NW  (NW),
            .RW  (PW),
            .BIT (PW - 1 - i),
            .SW  (XW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_v[i]),
            .in_rem    (sq_rem[i]),
            .in_root   (sq_root[i]),
            .in_side   (sq_side[i]),
            .out_valid (sq_v[i+1]),
            .out_rem   (sq_rem[i+1]),
            .out_root  (sq_root[i+1]),
            .out_side  (sq_side[i+1])
        );
    end

    // stage 7: divisor m + s and scaled dividend c
    logic          v7_reg;
    logic [RW-1:0] num7_reg;
    logic [DW-1:0] den7_reg;
    logic [1:0]    code7_reg;
    logic [1:0]    sq_code;
    logic [PW-1:0] sq_c, sq_m;

    assign {sq_code, sq_c, sq_m} = sq_side[PW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v7_reg <= sq_v[PW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num7_reg  <= RW'(sq_c) << FRAC_BITS;
            den7_reg  <= DW'(sq_m) + DW'(sq_root[PW]);
            code7_reg <= sq_code;
        end
    end

    // divider chain; the top quotient bit marks saturation
    logic          dv_v    [0:QW];
    logic [RW-1:0] dv_rem  [0:QW];
    logic [DW-1:0] dv_den  [0:QW];
    logic [QW-1:0] dv_quo  [0:QW];
    logic [1:0]    dv_code [0:QW];

    assign dv_v[0]    = v7_reg;
    assign dv_rem[0]  = num7_reg;
    assign dv_den[0]  = den7_reg;
    assign dv_quo[0]  = '0;
    assign dv_code[0] = code7_reg;

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        mcit_div_cell #(
            .RW  (RW),
            .DW  (DW),
            .QW  (QW),
            .BIT (QW - 1 - j)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_v[j]),
            .in_rem    (dv_rem[j]),
            .in_den    (dv_den[j]),
            .in_quo    (dv_quo[j]),
            .in_code   (dv_code[j]),
            .out_valid (dv_v[j+1]),
            .out_rem   (dv_rem[j+1]),
            .out_den   (dv_den[j+1]),
            .out_quo   (dv_quo[j+1]),
            .out_code  (dv_code[j+1])
        );
    end

    assign last_valid = dv_v[QW];

    // output register
    logic         ov_reg;
    logic [1:0]   oc_reg;
    logic [W-1:0] ot_reg, ot_next;
    logic         os_reg, os_next;
    logic [QW-1:0] fq;

    always_comb
    begin
        fq      = dv_quo[QW];
        ot_next = '0;
        os_next = 1'b0;
        if (dv_code[QW] == OUT_CONTACT)
        begin
            os_next = fq[W];
            ot_next = fq[W] ? {W{1'b1}} : fq[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (!ov_reg || dst.ready)
        begin
            ov_reg <= last_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ov_reg || dst.ready)
        begin
            oc_reg <= dv_code[QW];
            ot_reg <= ot_next;
            os_reg <= os_next;
        end
    end

    assign dst.valid          = ov_reg;
    assign dst.outcome        = oc_reg;
    assign dst.impact_time    = ot_reg;
    assign dst.time_saturated = os_reg;

endmodule

// File: rtl/mcit_checker.sv
// port level checks on the result channel and on src.ready
module mcit_assertions
    import mcit_pkg::*;
#(
    parameter int W = MCIT_COORD_BITS
)
(
    input logic         clk,
    input logic         rst_n,
    input logic         in_ready,
    input logic         valid,
    input logic         ready,
    input logic [1:0]   outcome,
    input logic [W-1:0] impact_time,
    input logic         time_saturated
);

    // time fields are zero unless a contact is reported
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && (outcome != OUT_CONTACT) |-> (impact_time == '0) && !time_saturated)
        else $error("time reported without contact");

    // saturation pins the time at full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && time_saturated |-> (impact_time == {W{1'b1}}))
        else $error("saturated time not at full scale");

    // only known codes leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (outcome == OUT_OVERLAP) || (outcome == OUT_CONTACT)
                  || (outcome == OUT_NONE))
        else $error("unknown outcome code");

    // input backpressure only comes from a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> valid && !ready)
        else $error("input stalled without output stall");

    // a stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(impact_time) && $stable(outcome))
        else $error("stalled result changed");

endmodule

bind moving_circle_impact_time mcit_assertions #(.W(COORD_BITS)) u_mcit_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (src.ready),
    .valid          (dst.valid),
    .ready          (dst.ready),
    .outcome        (dst.outcome),
    .impact_time    (dst.impact_time),
    .time_saturated (dst.time_saturated)
);

// File: test/mcit_tb_if.sv
`timescale 1ns / 100ps

// Channel interfaces are supplied by the RTL (mcit_in_if, mcit_out_if, mcit_cfg_if).
// This file holds the shared bench type for one expected result word.
package mcit_tb_pkg;
    import mcit_pkg::*;

    typedef struct packed {
        outcome_t    outcome;
        logic [15:0] impact_time;
        logic        time_saturated;
    } impact_word_t;
endpackage

// File: test/mcit_checker.sv
`timescale 1ns / 100ps

module mcit_checker
    import mcit_pkg::*;
    import mcit_tb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mcit_in_if.sink    src,
    mcit_out_if.sink   dst,
    mcit_cfg_if.sink   cfg,
    output int         fail_count,
    output int         pending,
    output int         n_contact,
    output int         n_overlap,
    output int         n_none,
    output int         n_sat
);
    logic [15:0]  radius_sum;
    impact_word_t expected_q[$];

    // integer square root by bisection on 160-bit values
    function automatic logic [159:0] isqrt(input logic [159:0] n);
        logic [159:0] lo, hi, mid;
        lo = 0;
        hi = 160'd1 << 80;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= n) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    // predicted result word for one pair of circles
    function automatic impact_word_t predict_impact(
        input logic signed [15:0] fx, fy, fvx, fvy, sx, sy, svx, svy);
        impact_word_t r;
        logic signed [159:0] dx, dy, dvx, dvy, h;
        logic [159:0] p, d2, c, a, m, disc, s, q;
        r.outcome = OUT_NONE;
        r.impact_time = '0;
        r.time_saturated = 1'b0;
        dx = fx - sx;
        dy = fy - sy;
        dvx = fvx - svx;
        dvy = fvy - svy;
        p = dx * dx + dy * dy;
        d2 = radius_sum * radius_sum;
        if (p <= d2)
        begin
            r.outcome = OUT_OVERLAP;
            return r;
        end
        c = p - d2;
        a = dvx * dvx + dvy * dvy;
        if (a == 0) return r;
        h = dx * dvx + dy * dvy;
        if (h >= 0) return r;
        m = -h;
        if (m * m < a * c) return r;
        disc = m * m - a * c;
        s = isqrt(disc);
        q = (c << 8) / (m + s);
        r.outcome = OUT_CONTACT;
        if (q > 160'hFFFF)
        begin
            r.impact_time = 16'hFFFF;
            r.time_saturated = 1'b1;
        end
        else r.impact_time = q[15:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    assign pending = expected_q.size();

    // watch channels, predict and compare
    always @(posedge clk or negedge rst_n)
    begin
        impact_word_t got, want;
        if (!rst_n)
        begin
            radius_sum <= 16'd128;
            expected_q = {};
            fail_count = 0;
            n_contact = 0;
            n_overlap = 0;
            n_none = 0;
            n_sat = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready) radius_sum <= cfg.data;
            if (src.valid && src.ready)
            begin
                want = predict_impact(src.first_x, src.first_y, src.first_vx,
                    src.first_vy, src.second_x, src.second_y, src.second_vx,
                    src.second_vy);
                expected_q.push_back(want);
                case (want.outcome)
                    OUT_CONTACT: n_contact++;
                    OUT_OVERLAP: n_overlap++;
                    default:     n_none++;
                endcase
                if (want.time_saturated) n_sat++;
            end
            if (dst.valid && dst.ready)
            begin
                got.outcome = outcome_t'(dst.outcome);
                got.impact_time = dst.impact_time;
                got.time_saturated = dst.time_saturated;
                if (expected_q.size() == 0)
                    report_mismatch("result word with nothing expected");
                else
                begin
                    want = expected_q.pop_front();
                    if (got.outcome !== want.outcome)
                        report_mismatch($sformatf("outcome %0d want %0d",
                            dst.outcome, want.outcome));
                    if (got.impact_time !== want.impact_time)
                        report_mismatch($sformatf("impact_time %h want %h",
                            got.impact_time, want.impact_time));
                    if (got.time_saturated !== want.time_saturated)
                        report_mismatch($sformatf("time_saturated %b want %b",
                            got.time_saturated, want.time_saturated));
                end
            end
        end
    end
endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
    import mcit_pkg::*;

    localparam int LATENCY  = 59;
    localparam int WD_LIMIT = 4000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count, pending, n_contact, n_overlap, n_none, n_sat;
    int   idle_cycles;
    bit   hold_dst;
    bit   timed_out;

    mcit_in_if  src_ch ();
    mcit_out_if dst_ch ();
    mcit_cfg_if cfg_ch ();

    moving_circle_impact_time dut (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src_ch.sink),
        .dst   (dst_ch.source),
        .cfg   (cfg_ch.sink)
    );

    mcit_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .src        (src_ch.sink),
        .dst        (dst_ch.sink),
        .cfg        (cfg_ch.sink),
        .fail_count (fail_count),
        .pending    (pending),
        .n_contact  (n_contact),
        .n_overlap  (n_overlap),
        .n_none     (n_none),
        .n_sat      (n_sat)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        src_ch.valid = 1'b0;
        {src_ch.first_x, src_ch.first_y, src_ch.first_vx, src_ch.first_vy} = '0;
        {src_ch.second_x, src_ch.second_y, src_ch.second_vx, src_ch.second_vy} = '0;
        dst_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        hold_dst = 1'b0;
        timed_out = 1'b0;
    end

    // receiver: random stalls, plus long hold-off when requested
    initial
    begin
        int w;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_dst)
            begin
                dst_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_dst = 1'b0;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (w > 0)
            begin
                dst_ch.ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            dst_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // watchdog: cycles with no acceptance anywhere
    always @(posedge clk)
    begin
        if ((src_ch.valid && src_ch.ready) || (dst_ch.valid && dst_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog expired");
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_pair(input logic [15:0] fx, fy, fvx, fvy, sx, sy, svx, svy,
                             input bit no_gap = 0);
        int w;
        w = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6));
        if (w > 0)
        begin
            src_ch.valid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        src_ch.valid <= 1'b1;
        src_ch.first_x <= fx;
        src_ch.first_y <= fy;
        src_ch.first_vx <= fvx;
        src_ch.first_vy <= fvy;
        src_ch.second_x <= sx;
        src_ch.second_y <= sy;
        src_ch.second_vx <= svx;
        src_ch.second_vy <= svy;
        @(posedge clk);
        while (!src_ch.ready) @(posedge clk);
    endtask

    task automatic stop_sending();
        src_ch.valid <= 1'b0;
    endtask

    // drain, then write the contact distance
    task automatic set_radius(input logic [15:0] v);
        stop_sending();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rnd_small();
        return 16'($signed($urandom_range(0, 8191)) - 4096);
    endfunction

    // well-formed approach: second circle heads toward first
    task automatic send_approach();
        logic signed [15:0] fx, fy, sx, sy, vx, vy;
        fx = rnd_small();
        fy = rnd_small();
        sx = rnd_small();
        sy = rnd_small();
        vx = 16'((fx - sx) >>> $urandom_range(2, 6));
        vy = 16'((fy - sy) >>> $urandom_range(2, 6));
        vx = vx + 16'($signed($urandom_range(0, 64)) - 32);
        send_pair(fx, fy, 16'($urandom_range(0, 15)), 0, sx, sy, vx, vy);
    endtask

    initial
    begin
        int k;
        logic [15:0] radii [6];
        radii = '{16'd0, 16'd65535, 16'd256, 16'd2048, 16'd40, 16'd12000};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset radius 0.5
        send_pair(0, 0, 0, 0, 0, 0, 0, 0);                       // overlap
        send_pair(16'h8000, 16'h8000, 0, 0, 16'h7fff, 16'h7fff, 0, 0); // still
        send_pair(0, 0, 0, 0, 16'h0a00, 0, 16'hff00, 0);          // head-on
        send_pair(0, 0, 0, 0, 16'h0a00, 0, 16'h0100, 0);          // moving apart
        send_pair(0, 0, 0, 0, 16'h0a00, 16'h0500, 16'hff00, 0);   // passing by
        send_pair(0, 0, 0, 0, 16'h0a00, 16'h0080, 16'hff00, 0);   // grazing
        send_pair(0, 0, 0, 0, 16'h7fff, 0, 16'hffff, 0);          // late, saturates
        send_pair(16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                  16'h7fff, 16'h8000, 16'h8000, 16'h7fff);        // extremes
        send_pair(16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                  16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        send_pair(16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, 0, 0, 0);
        send_pair(0, 16'h0400, 0, 16'hfe00, 0, 0, 0, 0);
        send_pair(16'h0100, 0, 0, 0, 0, 0, 0, 0);
        set_radius(16'd0);
        send_pair(0, 0, 0, 0, 0, 0, 0, 0);                        // touching at zero
        send_pair(16'h0001, 0, 16'hffff, 0, 0, 0, 0, 0);
        set_radius(16'hffff);
        send_pair(16'h8000, 16'h8000, 0, 0, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
        send_pair(16'h7fff, 0, 0, 0, 16'h8000, 0, 16'h7fff, 0);

        // pressure: receiver holds off while sender keeps offering
        set_radius(16'd256);
        hold_dst = 1'b1;
        for (k = 0; k < 100; k++) send_approach();

        // random phases over several radii
        for (int ph = 0; ph < 6; ph++)
        begin
            set_radius(radii[ph]);
            for (k = 0; k < 90; k++)
            begin
                case ($urandom_range(0, 9))
                    0, 1: send_pair(16'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom), 16'($urandom));
                    2: send_pair(rnd_small(), rnd_small(), 0, 0,
                                 rnd_small(), rnd_small(), 0, 0);
                    default: send_approach();
                endcase
            end
        end
        stop_sending();

        // wait for the tail
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("covered %0d contact, %0d overlap, %0d no-contact words (%0d saturated)",
                 n_contact, n_overlap, n_none, n_sat);
        $display("over seven contact distances incl. 0 and 0xffff, with a long output stall");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// File: filelist.f
rtl/mcit_pkg.sv
rtl/mcit_if.sv
rtl/mcit_sqrt_cell.sv
rtl/mcit_div_cell.sv
rtl/moving_circle_impact_time.sv
rtl/mcit_checker.sv
test/mcit_tb_if.sv
test/mcit_checker.sv
test/tb.sv
